FILE: sv/record_exchange_sort_top_assert.svh
// Assertion macros for the record exchange sort block.
// Used by the port-level checker; expects clk and rst_n in the calling scope.
`ifndef RECORD_EXCHANGE_SORT_TOP_ASSERT_SVH
`define RECORD_EXCHANGE_SORT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record_exchange_sort: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record_exchange_sort: check failed");

`endif

FILE: sv/res_pkg.sv
// Shared types and constants for the record exchange sort block.
// No dependencies; res_if, res_mem, res_ctrl, the top level and the testbench use it.
package res_pkg;

  localparam int KEY_W    = 64;
  localparam int SALARY_W = 32;
  localparam int TAG_W    = 32;

  localparam int MAX_RECORDS_DEF = 32;
  localparam int KEY_BYTES_DEF   = 8;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic signed [SALARY_W-1:0] salary;
    logic [TAG_W-1:0]           tag;
  } record_t;

  // One result beat as held in the output register.
  typedef struct packed {
    record_t rec;
    logic    final_flag;
    logic    overflow;
  } out_beat_t;

endpackage

FILE: sv/res_if.sv
// Valid/ready channel interfaces for the record exchange sort block.
// Depends on res_pkg for the field widths.
interface res_in_if;
  logic                                valid;
  logic                                ready;
  logic [res_pkg::KEY_W-1:0]           name_key;
  logic signed [res_pkg::SALARY_W-1:0] salary;
  logic [res_pkg::TAG_W-1:0]           record_tag;
  logic                                is_last;

  modport source (output valid, name_key, salary, record_tag, is_last, input ready);
  modport sink   (input valid, name_key, salary, record_tag, is_last, output ready);
endinterface

interface res_out_if;
  logic                                valid;
  logic                                ready;
  logic [res_pkg::KEY_W-1:0]           sorted_key;
  logic signed [res_pkg::SALARY_W-1:0] sorted_salary;
  logic [res_pkg::TAG_W-1:0]           sorted_tag;
  logic                                final_flag;
  logic                                overflow;

  modport source (output valid, sorted_key, sorted_salary, sorted_tag, final_flag, overflow,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_salary, sorted_tag, final_flag, overflow,
                  output ready);
endinterface

FILE: sv/res_mem.sv
// Record store: one write port and one read port with registered read data.
// Depends on res_pkg for the record type.
module res_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  res_pkg::record_t wr_rec,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output res_pkg::record_t rd_rec
);
  import res_pkg::*;

  record_t mem [DEPTH];
  record_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

FILE: sv/res_ctrl.sv
// Sequencer of the record exchange sort: load, in-memory exchange sort, output.
// Depends on res_pkg; drives the ports of res_mem.
module res_ctrl #(
  parameter int MAX_RECORDS = 32,
  parameter int KEY_BYTES   = 8,
  parameter int AW          = 5,
  parameter int CW          = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  res_pkg::record_t   in_rec,
  input  logic               in_is_last,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output res_pkg::out_beat_t out_beat,
  // record store
  output logic               mem_wr_en,
  output logic [AW-1:0]      mem_wr_addr,
  output res_pkg::record_t   mem_wr_rec,
  output logic               mem_rd_en,
  output logic [AW-1:0]      mem_rd_addr,
  input  res_pkg::record_t   mem_rd_rec
);
  import res_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES);
  localparam logic [CW-1:0]    CAP      = CW'(MAX_RECORDS);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LDI   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WBI   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OLD   = 3'd6;
  localparam logic [2:0] S_OHOLD = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  record_t       held_r, held_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_beat_r, out_beat_nxt;
  logic [CW-1:0] last_idx;
  record_t       load_rec;

  assign last_idx = count_r - CW'(1);

  always_comb begin
    load_rec     = in_rec;
    load_rec.key = in_rec.key & KEY_MASK;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = count_r[AW-1:0];
    mem_wr_rec    = load_rec;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = i_r;
    in_ready      = 1'b0;

    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CAP) begin
            mem_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_is_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        i_nxt = '0;
        if (count_r < CW'(2)) begin
          state_nxt = S_ORD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = '0;
          state_nxt   = S_LDI;
        end
      end
      S_LDI: begin
        // Record at position i becomes the running minimum of this pass.
        held_nxt    = mem_rd_rec;
        j_nxt       = i_r + AW'(1);
        mem_rd_en   = 1'b1;
        mem_rd_addr = i_r + AW'(1);
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (held_r.key > mem_rd_rec.key) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = j_r;
          mem_wr_rec  = held_r;
          held_nxt    = mem_rd_rec;
        end
        if (CW'(j_r) == last_idx) begin
          state_nxt = S_WBI;
        end else begin
          j_nxt       = j_r + AW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = j_r + AW'(1);
        end
      end
      S_WBI: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = i_r;
        mem_wr_rec  = held_r;
        if (CW'(i_r) + CW'(2) == count_r) begin
          // Final pass done; entry zero is read in S_ORD, so that the read sees this write.
          i_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          i_nxt       = i_r + AW'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = i_r + AW'(1);
          state_nxt   = S_LDI;
        end
      end
      S_ORD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = i_r;
        state_nxt   = S_OLD;
      end
      S_OLD: begin
        out_valid_nxt           = 1'b1;
        out_beat_nxt.rec        = mem_rd_rec;
        out_beat_nxt.final_flag = (CW'(i_r) == last_idx);
        out_beat_nxt.overflow   = dropped_r;
        state_nxt               = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_beat_r.final_flag) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            i_nxt       = i_r + AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = i_r + AW'(1);
            state_nxt   = S_OLD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r     <= held_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: sv/record_exchange_sort_top.sv
// Records load at one beat per cycle until the last record of a set; the set is then
// sorted in the store with input held off, and read out beat by beat after that.
// Output: the next beat is read from the store only once the sink takes the held one;
// the single record store port pair paces sort and output. In-memory exchange sort.
// Reset (rst_n, synchronous, active low) empties the store and clears the drop flag.
// Depends on res_pkg, res_if, res_mem and res_ctrl.
module record_exchange_sort_top #(
  parameter int MAX_RECORDS = res_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BYTES   = res_pkg::KEY_BYTES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  res_in_if.sink  in_bus,
  res_out_if.source out_bus
);
  import res_pkg::*;

  // Index width for the store and count width that also holds MAX_RECORDS itself.
  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  record_t       in_rec;
  out_beat_t     out_beat;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  record_t       mem_wr_rec;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  record_t       mem_rd_rec;

  // Gather the input beat into one record.
  assign in_rec.key    = in_bus.name_key;
  assign in_rec.salary = in_bus.salary;
  assign in_rec.tag    = in_bus.record_tag;

  // The sequencer owns every register of the block apart from the store itself.
  // It loads records, runs the exchange sort as read, compare and write-back steps
  // over the store, and then reads the sorted records out through an output register.
  res_ctrl #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BYTES   (KEY_BYTES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_rec      (in_rec),
    .in_is_last  (in_bus.is_last),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_beat    (out_beat),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_rec  (mem_wr_rec),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_rec  (mem_rd_rec)
  );

  // Key, salary and tag share one wide entry so that a swap is a single write.
  res_mem #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_rec  (mem_wr_rec),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_rec  (mem_rd_rec)
  );

  // Spread the registered output beat onto the result channel.
  assign out_bus.sorted_key    = out_beat.rec.key;
  assign out_bus.sorted_salary = out_beat.rec.salary;
  assign out_bus.sorted_tag    = out_beat.rec.tag;
  assign out_bus.final_flag    = out_beat.final_flag;
  assign out_bus.overflow      = out_beat.overflow;

endmodule

FILE: sv/res_checker.sv
// Port-level checker for record_exchange_sort_top, attached by bind.
// Depends on the assertion macros in record_exchange_sort_top_assert.svh.
`include "record_exchange_sort_top_assert.svh"

module res_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_is_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_final_flag
);

  // A result beat holds until it is taken.
  `RES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Loading and emitting never overlap.
  `RES_ASSERT_NOW(a_no_load_during_out, out_valid, !in_ready)
  // The last record of a set stops input while the set is sorted.
  `RES_ASSERT_NEXT(a_last_stops_input, in_valid && in_ready && in_is_last, !in_ready)
  // After the final beat of a run the block is ready for a new set at once.
  `RES_ASSERT_NEXT(a_final_reopens, out_valid && out_ready && out_final_flag,
                   in_ready && !out_valid)

endmodule

bind record_exchange_sort_top res_checker u_res_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_is_last     (in_bus.is_last),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_final_flag (out_bus.final_flag)
);

FILE: sim/tb_record_exchange_sort_top.sv
// Self-checking testbench for record_exchange_sort_top: record sets in, sorted beats out.
// Depends on res_pkg, res_if and the block itself; a built-in predictor supplies
// the expected beats, apart from those typed into the directed table.
`timescale 1ns / 1ps

module tb_record_exchange_sort_top;
  import res_pkg::*;

  // The block is built with its default sizes, and the predictor mirrors them.
  localparam int MAX_RECS = MAX_RECORDS_DEF;
  localparam int KEY_LEN  = KEY_BYTES_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK = ~64'd0 << (64 - 8 * KEY_LEN);

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  // The long output hold-off must outlast the sort of a full set, so the block is
  // left holding sorted beats while new records queue up.
  localparam int HOLD_CYCLES  = 900;
  // No accepted beat on either side for this many cycles means the block hung.
  // This is several times the worst quiet stretch of a correct run, which is
  // the hold-off above plus a sort and a few random stalls.
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 50;

  localparam logic [KEY_W-1:0] KEY_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] NAME_A     = 64'h4100_0000_0000_0000;
  localparam logic [KEY_W-1:0] NAME_AL    = 64'h414C_0000_0000_0000;
  localparam logic [KEY_W-1:0] NAME_ALI   = 64'h414C_4900_0000_0000;
  localparam logic [KEY_W-1:0] NAME_ALICE = 64'h414C_4943_4500_0000;
  localparam logic [KEY_W-1:0] NAME_ANN   = 64'h414E_4E00_0000_0000;
  localparam logic [KEY_W-1:0] NAME_BOB   = 64'h424F_4200_0000_0000;
  localparam logic [KEY_W-1:0] NAME_ZOE   = 64'h5A4F_4500_0000_0000;

  localparam logic signed [SALARY_W-1:0] SAL_MIN = 32'sh8000_0000;
  localparam logic signed [SALARY_W-1:0] SAL_MAX = 32'sh7FFF_FFFF;

  // One row of the directed table. Where typed is set, the expected beat is
  // written out in the row; it only appears on single-record sets, where the
  // answer is the record itself.
  typedef struct {
    record_t   rec;
    bit        last;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 16;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // Single-record sets at the field extremes.
    '{'{KEY_ONES, SAL_MIN, 32'hFFFF_FFFF}, 1'b1, 1'b1,
      '{'{KEY_ONES, SAL_MIN, 32'hFFFF_FFFF}, 1'b1, 1'b0}},
    '{'{64'd0, SAL_MAX, 32'h0000_0000}, 1'b1, 1'b1,
      '{'{64'd0, SAL_MAX, 32'h0000_0000}, 1'b1, 1'b0}},
    '{'{NAME_ALICE, -32'sd1, 32'h0000_0001}, 1'b1, 1'b1,
      '{'{NAME_ALICE, -32'sd1, 32'h0000_0001}, 1'b1, 1'b0}},
    // Interleaved duplicate keys: the exchange order among equal keys is
    // not stable, and the predictor has to agree with the block on it.
    '{'{NAME_BOB, 32'sd100, 32'd10}, 1'b0, 1'b0, '0},
    '{'{NAME_ANN, 32'sd200, 32'd11}, 1'b0, 1'b0, '0},
    '{'{NAME_BOB, 32'sd300, 32'd12}, 1'b0, 1'b0, '0},
    '{'{NAME_ANN, 32'sd400, 32'd13}, 1'b1, 1'b0, '0},
    // Keys that are prefixes of each other, plus both key extremes.
    '{'{KEY_ONES, SAL_MAX, 32'd20}, 1'b0, 1'b0, '0},
    '{'{NAME_ALICE, SAL_MIN, 32'd21}, 1'b0, 1'b0, '0},
    '{'{NAME_AL, 32'sd0, 32'd22}, 1'b0, 1'b0, '0},
    '{'{64'd0, -32'sd5, 32'd23}, 1'b0, 1'b0, '0},
    '{'{NAME_ALI, 32'sd7, 32'd24}, 1'b0, 1'b0, '0},
    '{'{NAME_A, 32'sd9, 32'hFFFF_FFFF}, 1'b1, 1'b0, '0},
    // Every key equal.
    '{'{NAME_ZOE, 32'sd1, 32'd30}, 1'b0, 1'b0, '0},
    '{'{NAME_ZOE, 32'sd2, 32'd31}, 1'b0, 1'b0, '0},
    '{'{NAME_ZOE, 32'sd3, 32'd32}, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  res_in_if  in_bus ();
  res_out_if out_bus ();

  record_exchange_sort_top #(
    .MAX_RECORDS (MAX_RECS),
    .KEY_BYTES   (KEY_LEN)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predictor state: the records of the set being loaded, whether any record
  // of that set was dropped, and the sorted run computed on its last record.
  record_t   stored_records [$];
  bit        drop_seen;
  out_beat_t sorted_run [$];

  // Beats the block still owes, oldest first.
  out_beat_t expected_beats [$];

  int mismatches;
  int records_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked;
  int holds_done;
  int hold_left;

  // Loads one record and, on the last one, sorts the set exactly the way the
  // block does: compare every position with every later one and swap on a
  // strictly greater key. The set then starts over empty.
  function automatic void store_and_sort(record_t r, bit last);
    record_t held;
    int      i;
    int      j;
    sorted_run.delete();
    if (stored_records.size() < MAX_RECS) begin
      r.key = r.key & KEY_MASK;
      stored_records.push_back(r);
    end else begin
      drop_seen = 1'b1;
    end
    if (!last) return;
    for (i = 0; i + 1 < stored_records.size(); i++) begin
      for (j = i + 1; j < stored_records.size(); j++) begin
        if (stored_records[i].key > stored_records[j].key) begin
          held              = stored_records[i];
          stored_records[i] = stored_records[j];
          stored_records[j] = held;
        end
      end
    end
    foreach (stored_records[k])
      sorted_run.push_back('{stored_records[k], k == stored_records.size() - 1, drop_seen});
    stored_records.delete();
    drop_seen = 1'b0;
  endfunction

  // Random record. Keys are a mix of fully random words, name-like strings and
  // a small pool of names, so that duplicates and shared prefixes are common.
  function automatic record_t random_record();
    record_t r;
    int      mode;
    int      len;
    int      c;
    mode = $urandom_range(9);
    if (mode < 3) begin
      r.key = {$urandom, $urandom};
    end else if (mode < 7) begin
      r.key = '0;
      len   = $urandom_range(KEY_LEN, 1);
      for (c = 0; c < len; c++)
        r.key[KEY_W-1-8*c -: 8] = 8'($urandom_range(8'h7A, 8'h41));
    end else begin
      case ($urandom_range(3))
        0:       r.key = NAME_ANN;
        1:       r.key = NAME_BOB;
        2:       r.key = NAME_AL;
        default: r.key = NAME_ALICE;
      endcase
    end
    case ($urandom_range(7))
      0:       r.salary = SAL_MIN;
      1:       r.salary = SAL_MAX;
      default: r.salary = $urandom;
    endcase
    r.tag = $urandom;
    return r;
  endfunction

  // Mostly small sets; now and then a set that exactly fills the store, or
  // one that runs past it so that records, the last among them, are dropped.
  function automatic int pick_set_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8)  return $urandom_range(MAX_RECS + 3, MAX_RECS + 1);
    if (roll < 14) return MAX_RECS;
    if (roll < 30) return 1;
    return $urandom_range(8, 2);
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one record beat, starting and ending at a falling edge. The
  // prediction is made at the rising edge that accepts the beat.
  task automatic offer_record(input record_t r, input bit last, input bit typed,
                              input out_beat_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.name_key   <= r.key;
    in_bus.salary     <= r.salary;
    in_bus.record_tag <= r.tag;
    in_bus.is_last    <= last;
    do @(posedge clk); while (!in_bus.ready);
    store_and_sort(r, last);
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      foreach (sorted_run[k]) expected_beats.push_back(sorted_run[k]);
    end
    records_sent++;
    @(negedge clk);
  endtask

  task automatic send_set(input int count);
    int n;
    for (n = 0; n < count; n++)
      offer_record(random_record(), n == count - 1, 1'b0, '0);
  endtask

  // Result side. Ready is redrawn at every falling edge, except while a long
  // hold-off runs; a hold-off starts whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      holds_done    <= holds_done + 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  // The same edge feeds the watchdog, which only counts cycles in which no
  // beat moves on either channel.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, sorted_key", out_bus.sorted_key, '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_bus.sorted_key !== want.rec.key)
            report_mismatch("sorted_key", out_bus.sorted_key, want.rec.key);
          if (out_bus.sorted_salary !== want.rec.salary)
            report_mismatch("sorted_salary", 64'(out_bus.sorted_salary), 64'(want.rec.salary));
          if (out_bus.sorted_tag !== want.rec.tag)
            report_mismatch("sorted_tag", 64'(out_bus.sorted_tag), 64'(want.rec.tag));
          if (out_bus.final_flag !== want.final_flag)
            report_mismatch("final_flag", 64'(out_bus.final_flag), 64'(want.final_flag));
          if (out_bus.overflow !== want.overflow)
            report_mismatch("overflow", 64'(out_bus.overflow), 64'(want.overflow));
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_record_exchange_sort_top: errors");
      $finish;
    end
  end

  initial begin
    int phase;
    int row;
    int phase_start;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.name_key   = '0;
    in_bus.salary     = '0;
    in_bus.record_tag = '0;
    in_bus.is_last    = 1'b0;
    out_bus.ready     = 1'b0;
    drop_seen         = 1'b0;
    mismatches        = 0;
    records_sent      = 0;
    quiet_cycles      = 0;
    holds_asked       = 0;
    holds_done        = 0;
    hold_left         = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Three phases of idling: a slow receiver, then a slow sender, then
    // neither side idles. The directed table runs first, in the slow
    // receiver phase, so its sorted runs pile up behind a stalled output.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct <= 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct <= 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_start = records_sent;

      if (phase == 0) begin
        for (row = 0; row < DIR_ROWS; row++)
          offer_record(directed_rows[row].rec, directed_rows[row].last,
                       directed_rows[row].typed, directed_rows[row].want);
      end else if (phase == 1) begin
        // Store overflow with the is_last beat itself dropped: the sort
        // must still run on the records that did fit.
        send_set(MAX_RECS + 2);
      end else begin
        // Long output hold-off while a full set loads and the next one is
        // already offered, so the block stalls its input for a while.
        holds_asked <= holds_asked + 1;
        send_set(MAX_RECS);
      end

      while (records_sent - phase_start < PHASE_ITEMS)
        send_set(pick_set_size());
    end
    in_bus.valid <= 1'b0;

    // Drain: every owed beat must arrive, and nothing may follow it.
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb_record_exchange_sort_top: clean");
    else
      $display("tb_record_exchange_sort_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/res_pkg.sv
sv/res_if.sv
sv/res_mem.sv
sv/res_ctrl.sv
sv/record_exchange_sort_top.sv
sv/res_checker.sv
sim/tb_record_exchange_sort_top.sv
